// ===== sv/cor_pkg.sv =====
// Shared codes and constants for the circle octant rasterizer.
// No dependencies; imported by cor_front, cor_back, the top level and the testbench.
package cor_pkg;

  // command field codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // algorithm_mode register codes
  localparam logic MODE_MIDPOINT  = 1'b0;
  localparam logic MODE_BRESENHAM = 1'b1;

  // register word index (byte address / 4)
  localparam logic REG_IDX_MODE = 1'b0;

  // decision constants
  localparam int MID_INIT    = 1;   // 1 - r
  localparam int BRES_INIT   = 3;   // 3 - 2r
  localparam int BRES_DIAG   = 18;  // 10 plus 4*(+1 on x, +1 on -y) folded in
  localparam int BRES_STRAIT = 10;  // 6 plus 4 from x+1
  localparam int MID_STEP    = 1;

  // pixels emitted per command
  localparam int PIX_PER_CMD = 8;

endpackage

// ===== sv/cor_fifo.sv =====
// Small register queue of step words between front and back.
// Depends on nothing but its parameters.
module cor_fifo #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== sv/cor_front.sv =====
// Front end: takes commands, runs the decision update, queues one step word.
// Uses cor_pkg.
module cor_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    command,
  input  logic [COORD_BITS-1:0]   center_x,
  input  logic [COORD_BITS-1:0]   center_y,
  input  logic [COORD_BITS-2:0]   radius,
  input  logic                    mode,
  input  logic                    q_full,
  output logic                    push,
  output logic [4*COORD_BITS:0]   job
);
  import cor_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int DEC = COORD_BITS + 4;

  logic [C-1:0]   x_r, x_nxt, y_r, y_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  logic [DEC-1:0] p_r, p_nxt;
  logic           active_r, active_nxt;
  logic           accept, fin;
  logic [DEC-1:0] xe, ye, re, step_sum;
  logic           p_neg, p_pos, diag;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign xe    = {{(DEC-C){1'b0}}, x_r};
  assign ye    = {{(DEC-C){y_r[C-1]}}, y_r};
  assign re    = {{(DEC-C+1){1'b0}}, radius};
  assign p_neg = p_r[DEC-1];
  assign p_pos = !p_neg && (p_r != '0);
  // diagonal move: midpoint on p >= 0, Bresenham on p > 0
  assign diag  = (mode == MODE_BRESENHAM) ? p_pos : !p_neg;

  always_comb begin
    if (mode == MODE_BRESENHAM) begin
      step_sum = p_r + (xe << 2) - (diag ? (ye << 2) : '0)
               + (diag ? DEC'(BRES_DIAG) : DEC'(BRES_STRAIT));
    end else begin
      step_sum = p_r + (xe << 1) - (diag ? (ye << 1) : '0) + DEC'(MID_STEP);
    end
  end

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    p_nxt      = p_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    active_nxt = active_r;
    fin        = 1'b0;
    push       = 1'b0;
    if (accept) begin
      if (command == CMD_START) begin
        x_nxt      = '0;
        y_nxt      = {1'b0, radius};
        cx_nxt     = center_x;
        cy_nxt     = center_y;
        p_nxt      = (mode == MODE_BRESENHAM) ? DEC'(BRES_INIT) - (re << 1)
                                              : DEC'(MID_INIT) - re;
        active_nxt = 1'b1;
        push       = 1'b1;
      end else if (active_r) begin
        x_nxt = x_r + 1'b1;
        y_nxt = diag ? y_r - 1'b1 : y_r;
        p_nxt = step_sum;
        fin   = $signed({y_nxt[C-1], y_nxt}) < $signed({1'b0, x_nxt});
        if (fin) begin
          active_nxt = 1'b0;
        end
        push = 1'b1;
      end
    end
  end

  // step word: fin | y | x | cy | cx
  assign job = {fin, y_nxt, x_nxt, cy_nxt, cx_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      p_r      <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      active_r <= 1'b0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      p_r      <= p_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== sv/cor_back.sv =====
// Back end: expands one step word into eight mirrored pixels, one per cycle while the output is not stalled.
// Uses cor_pkg; fed by cor_fifo.
module cor_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  logic [4*COORD_BITS:0]   job,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS+1:0]   pixel_x,
  output logic [COORD_BITS+1:0]   pixel_y,
  output logic                    last_of_step,
  output logic                    finished
);
  import cor_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int PX = COORD_BITS + 2;
  localparam int KW = $clog2(PIX_PER_CMD);

  logic [C-1:0]  cx, cy, x, y;
  logic          fin;
  logic [PX-1:0] xe, ye, ce_x, ce_y, a, b, dx, dy;
  logic [KW-1:0] k_r, k_nxt;
  logic          adv, last;
  logic          ov_r, ov_nxt;
  logic [PX-1:0] px_r, py_r;
  logic          last_r, fin_r;

  assign {fin, y, x, cy, cx} = job;

  assign xe   = {2'b00, x};
  assign ye   = {{2{y[C-1]}}, y};
  assign ce_x = {2'b00, cx};
  assign ce_y = {2'b00, cy};

  // order: (x,y) (-x,y) (x,-y) (-x,-y) (y,x) (-y,x) (y,-x) (-y,-x)
  assign a  = k_r[2] ? ye : xe;
  assign b  = k_r[2] ? xe : ye;
  assign dx = k_r[0] ? -a : a;
  assign dy = k_r[1] ? -b : b;

  assign adv  = job_valid && (!ov_r || out_ready);
  assign last = (k_r == KW'(PIX_PER_CMD - 1));
  assign pop  = adv && last;

  always_comb begin
    k_nxt  = adv ? k_r + 1'b1 : k_r;
    ov_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      k_r  <= k_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r   <= ce_x + dx;
      py_r   <= ce_y + dy;
      last_r <= last;
      fin_r  <= fin;
    end
  end

  assign out_valid    = ov_r;
  assign pixel_x      = px_r;
  assign pixel_y      = py_r;
  assign last_of_step = last_r;
  assign finished     = fin_r;

endmodule

// ===== sv/circle_octant_rasterizer_unit.sv =====
// Top level of the circle octant rasterizer: stream ports, APB mode register.
// Depends on cor_pkg, cor_front, cor_fifo, cor_back.
//
//  channel | direction | word contents
//  --------+-----------+-------------------------------------------------------
//  in_     | slave     | tuser: command; tdata: center_x, center_y, radius
//  out_    | master    | tdata: pixel_x, pixel_y; tlast: last_of_step;
//          |           | tuser: finished
//  cfg_    | APB       | word 0 (byte 0): algorithm_mode
//
// A start or an active step yields 8 pixel words at one word per cycle while
// the output is not stalled; the back end's single output register sets that
// pace. The front end updates the decision value as it accepts a command and
// takes the next command as long as the step queue has room. Steps while idle
// are taken and yield nothing.
// Reset (rst_n low, synchronous) idles the circle, empties the queue and
// clears algorithm_mode. Either side may stall independently.
module circle_octant_rasterizer_unit #(
  parameter int COORD_BITS  = 10,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [C-1:0] center_x, [2C-1:C] center_y, [3C-2:2C] radius, zero pad above
  input  logic [((3*COORD_BITS-1+7)/8)*8-1:0] in_tdata,
  // [0] command
  input  logic                      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [C+1:0] pixel_x, [2C+3:C+2] pixel_y, zero pad above
  output logic [((2*COORD_BITS+4+7)/8)*8-1:0] out_tdata,
  output logic                      out_tlast,
  // [0] finished
  output logic                      out_tuser,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import cor_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int PX    = COORD_BITS + 2;
  localparam int JW    = 4 * COORD_BITS + 1;
  localparam int OUT_W = ((2*COORD_BITS+4+7)/8)*8;

  logic          mode_r, mode_nxt;
  logic          cfg_wr, cfg_hit;
  logic          push, q_full, q_valid, pop;
  logic [JW-1:0] job_in, job_out;
  logic [PX-1:0] pixel_x, pixel_y;

  // ---- configuration port ----
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_IDX_MODE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? {31'd0, mode_r} : 32'd0;
  assign mode_nxt   = (cfg_wr && cfg_hit) ? cfg_pwdata[0] : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MIDPOINT;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // ---- front: decision update per command ----
  cor_front #(.COORD_BITS(C)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .command  (in_tuser),
    .center_x (in_tdata[C-1:0]),
    .center_y (in_tdata[2*C-1:C]),
    .radius   (in_tdata[3*C-2:2*C]),
    .mode     (mode_r),
    .q_full   (q_full),
    .push     (push),
    .job      (job_in)
  );

  // ---- step queue ----
  cor_fifo #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (job_in),
    .full     (q_full),
    .rd_en    (pop),
    .rd_valid (q_valid),
    .rd_data  (job_out)
  );

  // ---- back: eight mirrored pixels per step word ----
  cor_back #(.COORD_BITS(C)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (q_valid),
    .job          (job_out),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_step (out_tlast),
    .finished     (out_tuser)
  );

  // zero pad up to whole bytes
  assign out_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

// ===== tb/tb_circle_octant_rasterizer_unit.sv =====
// Self-checking testbench for circle_octant_rasterizer_unit: stream words in, pixel words out.
// Holds its own octant predictor and a scoreboard class; needs cor_pkg and the RTL only.
module tb_circle_octant_rasterizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cor_pkg::*;

  localparam int CB          = 10;                         // coordinate width
  localparam int PB          = CB + 2;                     // pixel coordinate width
  localparam int DB          = CB + 4;                     // decision width
  localparam int IN_W        = ((3 * CB - 1 + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * CB + 4 + 7) / 8) * 8;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYC  = 16;                         // quiet time before a register write
  localparam int TAIL_CYC    = 20;                         // quiet time at the end
  localparam int LONG_HOLD   = 200;                        // sink hold-off, in cycles
  localparam int WDOG_LIMIT  = 4000;                       // cycles with no word moving

  typedef logic [CB-1:0]        coord_t;
  typedef logic [CB-2:0]        radius_t;
  typedef logic [PB-1:0]        pix_t;
  typedef logic signed [DB-1:0] dec_t;

  typedef struct {
    pix_t px;
    pix_t py;
    logic last;
    logic fin;
  } pixel_t;

  // Scoreboard: tracks the circle state and holds the pixel words still owed.
  class raster_scoreboard;
    logic                 mode;
    coord_t               off_x;
    logic signed [CB-1:0] off_y;
    dec_t                 dec;
    bit                   running;
    coord_t               cx_l;
    coord_t               cy_l;
    pixel_t               pending_pixels[$];
    int                   mismatches;

    function new();
      mode       = MODE_MIDPOINT;
      off_x      = '0;
      off_y      = '0;
      dec        = '0;
      running    = 1'b0;
      cx_l       = '0;
      cy_l       = '0;
      mismatches = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function bit circle_running();
      return running;
    endfunction

    function int pending_count();
      return pending_pixels.size();
    endfunction

    // eight mirrored pixels of the current (x, y), in emission order
    function void push_octants(bit fin);
      int     cxi, cyi, xi, yi;
      int     dx[8];
      int     dy[8];
      pixel_t pix;
      cxi = cx_l;
      cyi = cy_l;
      xi  = off_x;
      yi  = off_y;
      dx  = '{xi, -xi, xi, -xi, yi, -yi, yi, -yi};
      dy  = '{yi, yi, -yi, -yi, xi, xi, -xi, -xi};
      for (int k = 0; k < PIX_PER_CMD; k++) begin
        pix.px   = pix_t'(cxi + dx[k]);
        pix.py   = pix_t'(cyi + dy[k]);
        pix.last = (k == PIX_PER_CMD - 1);
        pix.fin  = fin;
        pending_pixels.push_back(pix);
      end
    endfunction

    function void note_command(logic cmd, coord_t cx, coord_t cy, radius_t r);
      int xi, yi, p;
      bit fin;
      if (cmd == CMD_START) begin
        cx_l    = cx;
        cy_l    = cy;
        off_x   = '0;
        off_y   = {1'b0, r};
        dec     = (mode == MODE_BRESENHAM) ? dec_t'(3 - 2 * int'(r)) : dec_t'(1 - int'(r));
        running = 1'b1;
        push_octants(1'b0);
      end else if (running) begin
        xi = off_x;
        yi = off_y;
        p  = dec;
        if (mode == MODE_MIDPOINT) begin
          if (p < 0) begin
            p  = p + 2 * xi + 1;
            xi = xi + 1;
          end else begin
            p  = p + 2 * xi - 2 * yi + 1;
            xi = xi + 1;
            yi = yi - 1;
          end
        end else begin
          xi = xi + 1;
          if (p > 0) begin
            yi = yi - 1;
            p  = p + 4 * (xi - yi) + 10;
          end else begin
            p  = p + 4 * xi + 6;
          end
        end
        off_x = coord_t'(xi);
        off_y = coord_t'(yi);
        dec   = dec_t'(p);
        fin   = int'(off_y) < int'(off_x);
        if (fin) running = 1'b0;
        push_octants(fin);
      end
    endfunction

    function void check_pixel(pix_t px, pix_t py, logic last, logic fin);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("ERROR: unexpected pixel word x=%0d y=%0d last=%0b fin=%0b",
                   $signed(px), $signed(py), last, fin);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (want.px !== px || want.py !== py || want.last !== last || want.fin !== fin) begin
          if (mismatches < MAX_REPORTS)
            $display({"ERROR: pixel word: expected x=%0d y=%0d last=%0b fin=%0b,",
                      " got x=%0d y=%0d last=%0b fin=%0b"},
                     $signed(want.px), $signed(want.py), want.last, want.fin,
                     $signed(px), $signed(py), last, fin);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;    // center_x, center_y, radius from bit 0 up, zero pad
  logic             in_tuser;    // command
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;   // pixel_x, pixel_y from bit 0 up, zero pad
  logic             out_tlast;   // last_of_step
  logic             out_tuser;   // finished
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [2:0]       cfg_paddr;
  logic [31:0]      cfg_pwdata;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  raster_scoreboard sb = new();

  bit idle_on;        // random idle bursts allowed on both sides
  bit hold_request;   // asks the sink for one long hold-off
  int busy_words;     // input words that produce pixels

  circle_octant_rasterizer_unit #(
    .COORD_BITS (CB)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input side. All drive happens right after a rising edge, by NBA, so the
  // DUT sees stable values at the next edge. tready is sampled in the active
  // region after the edge, i.e. the value the DUT had at that edge.
  // ---------------------------------------------------------------------------

  // One word on the input channel; optional idle burst first. valid stays up
  // afterwards so back-to-back words need no drop.
  task automatic send_word(logic cmd, coord_t cx, coord_t cy, radius_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_W'({r, cy, cx});
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, cx, cy, r);
  endtask

  // Stop sending until every owed pixel is back, then give the block time to
  // swallow any idle step still in flight.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_mode(logic m);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * REG_IDX_MODE);
    cfg_pwdata  <= 32'(m);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_mode(m);
  endtask

  // Start a circle and step it until it finishes or max_steps is hit.
  // Step words carry random junk in the unused data fields.
  task automatic run_circle(coord_t cx, coord_t cy, radius_t r, int max_steps);
    int n;
    send_word(CMD_START, cx, cy, r);
    busy_words++;
    n = 0;
    while (sb.circle_running() && n < max_steps) begin
      send_word(CMD_STEP, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom));
      busy_words++;
      n++;
    end
  endtask

  // Mostly small full circles; some cut short by the next start, a few with
  // any radius at all. Now and then a step while idle, or a full pause.
  task automatic random_circle();
    int      pick;
    int      cap;
    radius_t r;
    pick = $urandom_range(0, 99);
    if (pick < 70)      r = radius_t'($urandom_range(0, 24));
    else if (pick < 88) r = radius_t'($urandom_range(25, 90));
    else                r = radius_t'($urandom);
    cap = (pick < 80) ? 1000 : $urandom_range(0, 10);
    run_circle(coord_t'($urandom), coord_t'($urandom), r, cap);
    if ($urandom_range(0, 4) == 0 && !sb.circle_running())
      send_word(CMD_STEP, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom));
    if (idle_on && $urandom_range(0, 19) == 0)
      settle();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int target;
    in_tvalid    <= 1'b0;
    in_tuser     <= CMD_START;
    in_tdata     <= '0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    rst_n        <= 1'b0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    busy_words   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle steps, zero radius, extreme centres and radius
    write_mode(MODE_MIDPOINT);
    send_word(CMD_STEP, '1, '1, '1);         // step while idle: nothing comes out
    run_circle('0, '0, '0, 100);             // zero radius, finishes on first step
    send_word(CMD_STEP, '0, '0, '0);
    run_circle('1, '1, '1, 2);               // top corner, largest radius
    run_circle('0, '1, '1, 1);               // start while active drops the old run
    settle();
    write_mode(MODE_BRESENHAM);              // rule changes mid-circle
    send_word(CMD_STEP, '0, '1, '0);
    send_word(CMD_STEP, '1, '0, '1);
    run_circle('1, '0, '0, 100);             // zero radius under Bresenham
    run_circle(coord_t'(512), coord_t'(512), radius_t'(1), 100);
    run_circle(coord_t'(300), coord_t'(700), radius_t'(6), 100);
    settle();
    write_mode(MODE_MIDPOINT);
    run_circle(coord_t'(40), coord_t'(900), radius_t'(4), 100);

    // random phases; the sink's long hold lands in the second one, the last
    // one runs without idling
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      if (phase == 0)      write_mode(MODE_BRESENHAM);
      else if (phase == 1) write_mode(MODE_MIDPOINT);
      else                 write_mode(logic'($urandom_range(0, 1)));
      if (phase == 1) hold_request = 1'b1;
      target = busy_words + 73;
      while (busy_words < target) begin
        idle_on = (phase != 3) && ($urandom_range(0, 2) != 0);
        random_circle();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("PASS circle_octant_rasterizer_unit");
    end else begin
      $display("FAIL circle_octant_rasterizer_unit");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Pixel sink: checks each accepted word, then picks next tready. The long
  // hold is counted here so the sender keeps pushing and the queue backs up.
  // ---------------------------------------------------------------------------
  initial begin : pixel_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_pixel(out_tdata[PB-1:0], out_tdata[2*PB-1:PB], out_tlast, out_tuser);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD - 1;
        out_tready   <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles in a row where no word moves on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no word moved for %0d cycles", WDOG_LIMIT);
    $display("FAIL circle_octant_rasterizer_unit");
    $finish;
  end

endmodule
